>>> sv/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// shared types, constants and control structs of the sparse triplet transpose
// ----------------------------------------------------------------------------
package sst_pkg;

   // default sizes
   localparam int CAPACITY = 64;
   localparam int MAX_DIM  = 256;

   // field widths
   localparam int ROW_W = 8;
   localparam int COL_W = 8;
   localparam int VAL_W = 32;
   localparam int CFG_W = 9;

   // csr map
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COL_COUNT = 1'd1;
   localparam logic [CFG_W-1:0] ROW_COUNT_RST = 9'd256;
   localparam logic [CFG_W-1:0] COL_COUNT_RST = 9'd256;

   typedef struct packed {
      logic [ROW_W-1:0]        entry_row;
      logic [COL_W-1:0]        entry_col;
      logic signed [VAL_W-1:0] entry_value;
      logic                    last_entry;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]        out_row;
      logic [COL_W-1:0]        out_col;
      logic signed [VAL_W-1:0] out_value;
      logic                    last_result;
      logic                    some_dropped;
   } rsp_type;

   // one stored triplet
   typedef struct packed {
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
      logic signed [VAL_W-1:0] value;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_PREFIX,
      ST_SC_RD,
      ST_SC_CUR,
      ST_SC_WR,
      ST_EM_RD,
      ST_EM_LD,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic update;
      logic idx_clear;
      logic idx_inc;
      logic pf_step;
      logic sc_rd;
      logic sc_cur;
      logic sc_wr;
      logic em_rd;
      logic em_ld;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic last_held;
      logic pf_done;
      logic more;
      logic sc_skip;
      logic out_free;
   } status_type;

endpackage

>>> sv/sparse_triplet_transpose.sv
// ----------------------------------------------------------------------------
// sparse_triplet_transpose
// fast transpose of a sparse matrix given as (row, column, value) triplets
// ----------------------------------------------------------------------------
//
//   channel | ports                                      | dir | moves
//   --------+--------------------------------------------+-----+----------------------
//   req     | req_valid, req_ready, req_data             | in  | one source triplet
//   rsp     | rsp_valid, rsp_ready, rsp_data             | out | one transposed triplet
//   csr     | csr_valid, csr_ready, csr_index, csr_wdata | in  | row_count / col_count
//
// a request's column count is read at acceptance and written back next
// a last request then runs a prefix sum over the columns, a scatter of the n kept
// entries and their emission while rsp_ready stays high, and then clears the run
// reset is synchronous; column counts clear at once through per-column valid bits
// a stalled rsp holds emission; a new request may be taken while the final result of
// the previous run still waits in the output register
//
module sparse_triplet_transpose #(
   parameter int CAPACITY = sst_pkg::CAPACITY,
   parameter int MAX_DIM  = sst_pkg::MAX_DIM
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  sst_pkg::req_type                req_data,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output sst_pkg::rsp_type                rsp_data,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sst_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sst_pkg::CFG_W-1:0]       csr_wdata
);

   sst_pkg::cmd_type    cmd;
   sst_pkg::status_type status;

   // registers take a write in any cycle
   assign csr_ready = 1'b1;

   // sequencer
   sst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // stores, counters and output register
   sst_dp #(
      .CAPACITY (CAPACITY),
      .MAX_DIM  (MAX_DIM)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // the count write-back cycle follows every accepted request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted during count write-back");

   // a result is loaded only into a free output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.em_ld |-> !rsp_valid)
      else $error("output register overwritten");

   // one phase command at a time
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.update, cmd.pf_step, cmd.sc_rd, cmd.sc_cur,
                cmd.sc_wr, cmd.em_rd, cmd.em_ld, cmd.finish}))
      else $error("conflicting datapath commands");

   // the run clears and the block returns to taking requests
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> req_ready)
      else $error("block not idle after run clear");

endmodule

>>> sv/sst_ctrl.sv
// ----------------------------------------------------------------------------
// sst_ctrl
// sequencer for load, prefix sum, scatter and emission phases
// ----------------------------------------------------------------------------
module sst_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sst_pkg::status_type    status,
   output sst_pkg::cmd_type       cmd
);

   sst_pkg::state_type state_ff;
   sst_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sst_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         sst_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = sst_pkg::ST_UPDATE;
            end
         end
         sst_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            if (status.last_held) begin
               cmd.idx_clear = 1'b1;
               state_in      = sst_pkg::ST_PREFIX;
            end else begin
               state_in = sst_pkg::ST_IDLE;
            end
         end
         sst_pkg::ST_PREFIX: begin
            cmd.pf_step = 1'b1;
            if (status.pf_done) begin
               cmd.idx_clear = 1'b1;
               state_in      = sst_pkg::ST_SC_RD;
            end
         end
         sst_pkg::ST_SC_RD: begin
            if (status.more) begin
               cmd.sc_rd = 1'b1;
               state_in  = sst_pkg::ST_SC_CUR;
            end else begin
               cmd.idx_clear = 1'b1;
               state_in      = sst_pkg::ST_EM_RD;
            end
         end
         sst_pkg::ST_SC_CUR: begin
            if (status.sc_skip) begin
               cmd.idx_inc = 1'b1;
               state_in    = sst_pkg::ST_SC_RD;
            end else begin
               cmd.sc_cur = 1'b1;
               state_in   = sst_pkg::ST_SC_WR;
            end
         end
         sst_pkg::ST_SC_WR: begin
            cmd.sc_wr   = 1'b1;
            cmd.idx_inc = 1'b1;
            state_in    = sst_pkg::ST_SC_RD;
         end
         sst_pkg::ST_EM_RD: begin
            if (!status.more) begin
               state_in = sst_pkg::ST_FINISH;
            end else if (status.out_free) begin
               cmd.em_rd = 1'b1;
               state_in  = sst_pkg::ST_EM_LD;
            end
         end
         sst_pkg::ST_EM_LD: begin
            cmd.em_ld   = 1'b1;
            cmd.idx_inc = 1'b1;
            state_in    = sst_pkg::ST_EM_RD;
         end
         sst_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = sst_pkg::ST_IDLE;
         end
         default: begin
            state_in = sst_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> sv/sst_dp.sv
// ----------------------------------------------------------------------------
// sst_dp
// datapath: csr, entry and ordered stores, column counts and cursors, output
// ----------------------------------------------------------------------------
module sst_dp #(
   parameter int CAPACITY = sst_pkg::CAPACITY,
   parameter int MAX_DIM  = sst_pkg::MAX_DIM
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sst_pkg::req_type                req_data,
   input  logic                            csr_valid,
   input  logic [sst_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sst_pkg::CFG_W-1:0]       csr_wdata,
   input  sst_pkg::cmd_type                cmd,
   output sst_pkg::status_type             status,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output sst_pkg::rsp_type                rsp_data
);

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int DIM_W  = $clog2(MAX_DIM);
   localparam int IDX_W  = (CNT_W > sst_pkg::CFG_W) ? CNT_W : sst_pkg::CFG_W;

   // csr
   logic [sst_pkg::CFG_W-1:0] row_count_ff;
   logic [sst_pkg::CFG_W-1:0] col_count_ff;
   logic [sst_pkg::CFG_W-1:0] cols;

   // held request
   sst_pkg::entry_type hold_ff;
   logic               last_ff;
   logic               keep_ff;
   logic               keep_in;

   // run state
   logic [CNT_W-1:0] loaded_ff;
   logic             dropped_ff;
   logic [IDX_W-1:0] idx_ff;

   // column counts
   logic [CNT_W-1:0]   cnt_mem [MAX_DIM];
   logic [MAX_DIM-1:0] cnt_vld_ff;
   logic [CNT_W-1:0]   cnt_rd_ff;
   logic               cnt_rd_vld_ff;
   logic [CNT_W-1:0]   cnt_rd_val;
   logic [DIM_W-1:0]   cnt_raddr;

   // prefix sum pipe
   logic             pf_issue;
   logic             pf_vld_ff;
   logic [DIM_W-1:0] pf_addr_ff;
   logic [CNT_W-1:0] pos_ff;

   // stores and cursors
   sst_pkg::entry_type ent_mem [CAPACITY];
   sst_pkg::entry_type ent_rd_ff;
   logic [CNT_W-1:0]   cur_mem [MAX_DIM];
   logic [CNT_W-1:0]   cur_rd_ff;
   sst_pkg::entry_type ord_mem [CAPACITY];
   sst_pkg::entry_type ord_rd_ff;

   // output register
   logic             rsp_valid_ff;
   sst_pkg::rsp_type rsp_data_ff;

   // row_count is held for software only
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= sst_pkg::ROW_COUNT_RST;
         col_count_ff <= sst_pkg::COL_COUNT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            sst_pkg::REG_ROW_COUNT: row_count_ff <= csr_wdata;
            sst_pkg::REG_COL_COUNT: col_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cols = (col_count_ff > MAX_DIM) ? sst_pkg::CFG_W'(MAX_DIM) : col_count_ff;

   assign keep_in = (loaded_ff < CNT_W'(CAPACITY)) &&
                    ({1'b0, req_data.entry_col} < cols);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         hold_ff.row   <= req_data.entry_row;
         hold_ff.col   <= req_data.entry_col;
         hold_ff.value <= req_data.entry_value;
         last_ff       <= req_data.last_entry;
         keep_ff       <= keep_in;
      end
   end

   assign pf_issue = cmd.pf_step && (idx_ff < IDX_W'(cols));

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff  <= '0;
         dropped_ff <= 1'b0;
         idx_ff     <= '0;
         pf_vld_ff  <= 1'b0;
         pos_ff     <= '0;
         cnt_vld_ff <= '0;
      end else begin
         pf_vld_ff <= pf_issue;
         if (cmd.finish) begin
            loaded_ff  <= '0;
            dropped_ff <= 1'b0;
            cnt_vld_ff <= '0;
         end else if (cmd.update) begin
            if (keep_ff) begin
               loaded_ff                          <= loaded_ff + CNT_W'(1);
               cnt_vld_ff[DIM_W'(hold_ff.col)]    <= 1'b1;
            end else begin
               dropped_ff <= 1'b1;
            end
         end
         if (cmd.idx_clear) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc || pf_issue) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (cmd.idx_clear) begin
            pos_ff <= '0;
         end else if (pf_vld_ff) begin
            pos_ff <= pos_ff + cnt_rd_val;
         end
      end
   end

   // count memory, read at acceptance and written back in the update state of each request
   assign cnt_raddr  = cmd.accept ? DIM_W'(req_data.entry_col) : DIM_W'(idx_ff);
   assign cnt_rd_val = cnt_rd_vld_ff ? cnt_rd_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.update && keep_ff) begin
         cnt_mem[DIM_W'(hold_ff.col)] <= cnt_rd_val + CNT_W'(1);
      end
      cnt_rd_ff     <= cnt_mem[cnt_raddr];
      cnt_rd_vld_ff <= cnt_vld_ff[cnt_raddr];
      pf_addr_ff    <= DIM_W'(idx_ff);
   end

   // entry store
   always_ff @(posedge clock) begin
      if (cmd.update && keep_ff) begin
         ent_mem[ADDR_W'(loaded_ff)] <= hold_ff;
      end
      if (cmd.sc_rd) begin
         ent_rd_ff <= ent_mem[ADDR_W'(idx_ff)];
      end
   end

   // column cursors
   always_ff @(posedge clock) begin
      if (pf_vld_ff) begin
         cur_mem[pf_addr_ff] <= pos_ff;
      end else if (cmd.sc_wr) begin
         cur_mem[DIM_W'(ent_rd_ff.col)] <= cur_rd_ff + CNT_W'(1);
      end
      if (cmd.sc_cur) begin
         cur_rd_ff <= cur_mem[DIM_W'(ent_rd_ff.col)];
      end
   end

   // ordered store, row and column swapped
   always_ff @(posedge clock) begin
      if (cmd.sc_wr && (cur_rd_ff < CNT_W'(CAPACITY))) begin
         ord_mem[ADDR_W'(cur_rd_ff)] <= '{row:   ent_rd_ff.col,
                                          col:   ent_rd_ff.row,
                                          value: ent_rd_ff.value};
      end
      if (cmd.em_rd) begin
         ord_rd_ff <= ord_mem[ADDR_W'(idx_ff)];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.em_ld) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.em_ld) begin
         rsp_data_ff.out_row      <= ord_rd_ff.row;
         rsp_data_ff.out_col      <= ord_rd_ff.col;
         rsp_data_ff.out_value    <= ord_rd_ff.value;
         rsp_data_ff.last_result  <= (idx_ff + IDX_W'(1)) == IDX_W'(loaded_ff);
         rsp_data_ff.some_dropped <= dropped_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.last_held = last_ff;
   assign status.pf_done   = (idx_ff >= IDX_W'(cols)) && !pf_vld_ff;
   assign status.more      = idx_ff < IDX_W'(loaded_ff);
   assign status.sc_skip   = {1'b0, ent_rd_ff.col} >= cols;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

endmodule

>>> bench/transpose_checker.sv
// ----------------------------------------------------------------------------
// transpose_checker
// watches the request, result and register channels of the sparse triplet
// transpose, predicts every transposed triplet and compares it field by field
// ----------------------------------------------------------------------------
module transpose_checker
   import sst_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output int                   mismatches,
   output int                   owed,
   output int                   compared
);
   timeunit 1ns;
   timeprecision 1ps;

   entry_type        kept_q[$];
   rsp_type          transposed_q[$];
   logic [CFG_W-1:0] cols_cfg = COL_COUNT_RST;
   logic             run_dropped = 1'b0;
   int               errs = 0;
   int               seen = 0;

   function automatic void compare_field(string field, logic signed [VAL_W:0] want,
                                         logic signed [VAL_W:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         errs++;
      end
   endfunction

   // keep or drop one entry; on the last one lay out the run column by column
   function automatic void load_entry(req_type item);
      int unsigned usable;
      int unsigned n;
      int unsigned k;
      usable = (cols_cfg > MAX_DIM) ? MAX_DIM : cols_cfg;
      if (kept_q.size() >= CAPACITY || item.entry_col >= usable)
         run_dropped = 1'b1;
      else
         kept_q.push_back(entry_type'{row: item.entry_row, col: item.entry_col,
                                     value: item.entry_value});
      if (item.last_entry) begin
         n = kept_q.size();
         k = 0;
         for (int c = 0; c < usable; c++) begin
            foreach (kept_q[i]) begin
               if (kept_q[i].col == c) begin
                  k++;
                  transposed_q.push_back(rsp_type'{out_row: kept_q[i].col,
                                                   out_col: kept_q[i].row,
                                                   out_value: kept_q[i].value,
                                                   last_result: (k == n),
                                                   some_dropped: run_dropped});
               end
            end
         end
         kept_q.delete();
         run_dropped = 1'b0;
      end
   endfunction

   function automatic void check_result(rsp_type got);
      rsp_type want;
      if (transposed_q.size() == 0) begin
         $error("result with nothing owed: row %0d col %0d value %0d",
                got.out_row, got.out_col, got.out_value);
         errs++;
         return;
      end
      want = transposed_q.pop_front();
      compare_field("out_row", want.out_row, got.out_row);
      compare_field("out_col", want.out_col, got.out_col);
      compare_field("out_value", want.out_value, got.out_value);
      compare_field("last_result", want.last_result, got.last_result);
      compare_field("some_dropped", want.some_dropped, got.some_dropped);
      seen++;
   endfunction

   // row_count never changes a result, so only col_count is tracked
   always @(posedge clock) begin
      if (reset) begin
         kept_q.delete();
         transposed_q.delete();
         cols_cfg    = COL_COUNT_RST;
         run_dropped = 1'b0;
      end else begin
         if (csr_valid && csr_ready && csr_index == REG_COL_COUNT)
            cols_cfg = csr_wdata;
         if (rsp_valid && rsp_ready)
            check_result(rsp_data);
         if (req_valid && req_ready)
            load_entry(req_data);
      end
      mismatches <= errs;
      owed       <= transposed_q.size();
      compared   <= seen;
   end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives the sparse triplet transpose with directed corner runs and random
// matrices under several dimension settings, with random gaps on both sides;
// a checker beside the block predicts and compares every transposed triplet
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sst_pkg::*;

   localparam int DIRECTED_ITEMS = 19;
   localparam int RANDOM_ITEMS   = 150;
   // prefix sum over every column, scatter and emission of a full store, slack
   localparam int DRAIN_CYCLES   = 3 + MAX_DIM + 5 * CAPACITY + 16;
   localparam int LIMIT_CYCLES   = 400000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = REG_ROW_COUNT;
   logic [CFG_W-1:0]     csr_wdata = '0;

   int                   mismatches;
   int                   owed;
   int                   compared;

   // stimulus bookkeeping
   int                   entries_sent = 0;
   int                   runs_sent = 0;
   int                   settings_used = 0;
   int                   cycle_count = 0;
   logic [CFG_W-1:0]     cur_cols = COL_COUNT_RST;
   logic                 steady = 1'b0;
   logic                 filled = 1'b0;

   // result side pacing
   logic                 rsp_taken = 1'b0;
   int                   rsp_hold = 0;

   sparse_triplet_transpose dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   transpose_checker transpose_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .owed       (owed),
      .compared   (compared)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // hard stop well beyond the slowest correct run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb: timeout after %0d cycles, %0d results still owed", cycle_count, owed);
         $display("tb: FAIL");
         $finish;
      end
   end

   // idle cycles before a request or after a result, none in steady stretches
   function automatic int pick_gap();
      if (steady)
         return 0;
      return $urandom_range(0, 4);
   endfunction

   // handshakes are sampled at the falling edge, where every input has settled
   always @(negedge clock) rsp_taken = (rsp_valid === 1'b1) && rsp_ready;

   // result side: after each taken result hold ready low for a drawn stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
         rsp_ready <= (rsp_hold == 0);
      end else if (rsp_taken || !rsp_ready) begin
         rsp_hold = pick_gap();
         rsp_ready <= (rsp_hold == 0);
      end
   end

   // one request; valid stays up across back-to-back requests
   task automatic send_entry(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                             input logic [VAL_W-1:0] value, input logic last);
      int   gap;
      logic taken;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{entry_row: row, entry_col: col, entry_value: value, last_entry: last};
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      entries_sent++;
      if (last)
         runs_sent++;
   endtask

   // let every owed result arrive, then give the block time to wind down
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write row_count then col_count back to back, only while idle
   task automatic set_dims(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
      logic taken;
      for (int i = 0; i < 2; i++) begin
         csr_valid <= 1'b1;
         csr_index <= (i == 0) ? REG_ROW_COUNT : REG_COL_COUNT;
         csr_wdata <= (i == 0) ? rows : cols;
         do begin
            @(negedge clock);
            taken = csr_ready;
            @(posedge clock);
         end while (!taken);
      end
      csr_valid <= 1'b0;
      cur_cols = cols;
      settings_used++;
   endtask

   // one matrix; mostly columns in range, some strays unless filling the store
   task automatic random_run(input int len, input logic fill);
      int               usable;
      logic [COL_W-1:0] col;
      logic [VAL_W-1:0] value;
      usable = (cur_cols > MAX_DIM) ? MAX_DIM : cur_cols;
      for (int i = 0; i < len; i++) begin
         if (usable == 0 || (!fill && $urandom_range(0, 6) == 0))
            col = COL_W'($urandom_range(0, 255));
         else
            col = COL_W'($urandom_range(0, usable - 1));
         case ($urandom_range(0, 15))
            0: value = 32'h8000_0000;
            1: value = 32'h7fff_ffff;
            2: value = 32'h0000_0000;
            3: value = 32'hffff_ffff;
            default: value = $urandom;
         endcase
         send_entry(ROW_W'($urandom_range(0, 255)), col, value, i == len - 1);
      end
   endtask

   initial begin
      logic [CFG_W-1:0] rows_pick;
      logic [CFG_W-1:0] cols_pick;
      int               phase_runs;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset dimensions: field extremes, both corners of the column range
      send_entry(8'd0,   8'd0,   32'h8000_0000, 1'b0);
      send_entry(8'd0,   8'd255, 32'h7fff_ffff, 1'b0);
      send_entry(8'd255, 8'd255, 32'hffff_ffff, 1'b0);
      send_entry(8'd255, 8'd0,   32'h0000_0000, 1'b0);
      send_entry(8'd170, 8'd85,  32'haaaa_aaaa, 1'b0);
      send_entry(8'd85,  8'd170, 32'h5555_5555, 1'b1);
      // run of a single entry
      send_entry(8'd7,   8'd3,   32'h1234_5678, 1'b1);

      // row_count of zero: every row out of range but still kept
      settle();
      set_dims(9'd0, 9'd4);
      send_entry(8'd10,  8'd3,   32'hdead_beef, 1'b0);
      // column right at the bound is dropped
      send_entry(8'd9,   8'd4,   32'h0000_0001, 1'b0);
      send_entry(8'd200, 8'd0,   32'hffff_fffe, 1'b0);
      // the last request itself dropped, run still emitted with the flag
      send_entry(8'd255, 8'd7,   32'h0bad_f00d, 1'b1);
      // empty run: nothing kept, nothing emitted, drop lost
      send_entry(8'd1,   8'd5,   32'h0000_0002, 1'b1);
      // drop flag must be clear again on the next run
      send_entry(8'd1,   8'd1,   32'h0000_0003, 1'b1);

      // col_count of zero drops everything
      settle();
      set_dims(9'd511, 9'd0);
      send_entry(8'd3,   8'd0,   32'h0000_0004, 1'b1);

      // col_count above the maximum behaves as the maximum
      settle();
      set_dims(9'd256, 9'd511);
      send_entry(8'd1,   8'd255, 32'h8000_0001, 1'b0);
      send_entry(8'd2,   8'd200, 32'h7fff_fffe, 1'b1);

      // single column
      settle();
      set_dims(9'd1, 9'd1);
      send_entry(8'd5,   8'd0,   32'h0000_0005, 1'b0);
      send_entry(8'd6,   8'd0,   32'hffff_fffb, 1'b0);
      send_entry(8'd7,   8'd1,   32'h0000_0007, 1'b1);

      // random matrices, a few runs per dimension setting
      phase_runs = 3;
      while (entries_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         if (!filled && entries_sent >= DIRECTED_ITEMS + 40) begin
            // overfill the store so the capacity drop shows up
            settle();
            set_dims(CFG_W'($urandom_range(0, 511)), 9'd256);
            steady = 1'b0;
            random_run($urandom_range(CAPACITY + 2, CAPACITY + 6), 1'b1);
            filled     = 1'b1;
            phase_runs = 0;
         end else begin
            if (phase_runs >= 3) begin
               settle();
               case ($urandom_range(0, 3))
                  0: rows_pick = 9'd0;
                  1: rows_pick = 9'd511;
                  2: rows_pick = 9'd256;
                  default: rows_pick = CFG_W'($urandom_range(0, 511));
               endcase
               case ($urandom_range(0, 9))
                  0: cols_pick = 9'd0;
                  1: cols_pick = 9'd1;
                  2: cols_pick = 9'd256;
                  3: cols_pick = 9'd511;
                  4: cols_pick = CFG_W'($urandom_range(257, 510));
                  5, 6: cols_pick = CFG_W'($urandom_range(2, 8));
                  default: cols_pick = CFG_W'($urandom_range(1, 256));
               endcase
               set_dims(rows_pick, cols_pick);
               phase_runs = 0;
            end
            // some runs without any idling on either side
            steady = ($urandom_range(0, 3) == 0);
            random_run($urandom_range(1, 10), 1'b0);
            phase_runs++;
         end
      end

      steady = 1'b0;
      settle();

      $display("tb: %0d requests in %0d matrices over %0d dimension settings",
               entries_sent, runs_sent, settings_used);
      $display("tb: %0d transposed triplets compared, store overfilled once: %0d",
               compared, filled);
      if (mismatches == 0 && owed == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
